[hdl/cordic_sc_pkg.sv]
// ----------------------------------------------------------------------------
// cordic_sc_pkg
// Shared types and constants for the pipelined cordic sine and cosine block.
// ----------------------------------------------------------------------------
package cordic_sc_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    // quadrant limits and starting gain of the rotation
    localparam word_t QUARTER_TURN   = 32'h3fffffff;
    localparam word_t THREE_QUARTERS = 32'hbffffffd;
    localparam word_t START_GAIN     = 32'hb2458939;

    // arctangent of 2^-i, one turn is 2^32, entries past index 29 are zero
    localparam word_t STEP_ANGLES [0:31] = '{
        32'h1fffffff, 32'h12e4051d, 32'h09fb385b, 32'h051111d4,
        32'h028b0d43, 32'h0145d7e1, 32'h00a2f61e, 32'h00517c55,
        32'h0028be53, 32'h00145f2e, 32'h000a2f98, 32'h000517cc,
        32'h00028be6, 32'h000145f3, 32'h0000a2f9, 32'h0000517c,
        32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
        32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000a, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

endpackage

[hdl/cordic_sc_step.sv]
// ----------------------------------------------------------------------------
// cordic_sc_step
// One registered cordic rotation step with its own valid bit and ready.
// ----------------------------------------------------------------------------
module cordic_sc_step
    import cordic_sc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  valid_in,
    output logic  ready_up,
    input  word_t x_in,
    input  word_t y_in,
    input  word_t z_in,
    output logic  valid_out,
    input  logic  ready_dn,
    output word_t x_out,
    output word_t y_out,
    output word_t z_out
);

    localparam logic [4:0] K = 5'(STEP);

    logic  valid_reg;
    word_t x_reg, y_reg, z_reg;
    word_t x_next, y_next, z_next;
    word_t xs, ys, angle;

    // stage takes new data when empty or when its content moves on
    assign ready_up = !valid_reg || ready_dn;

    // shifted operands and rotation direction
    always_comb
    begin
        xs    = word_t'($signed(x_in) >>> K);
        ys    = word_t'($signed(y_in) >>> K);
        angle = STEP_ANGLES[K];
        if (z_in >= QUARTER_TURN)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - angle;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + angle;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_up)
            valid_reg <= valid_in;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule

[hdl/cordic_sine_cosine_top.sv]
// Pipeline: one quadrant stage, then one register stage per rotation step.
// Throughput: one phase per cycle while the output is ready; each stage has its own
// valid bit, so a stalled output only holds the stages behind it that are full and
// empty stages still fill.
// Reset: asynchronous active-low, clears every valid bit; data registers keep contents.
// ----------------------------------------------------------------------------
// cordic_sine_cosine_top
// Fully pipelined cordic sine and cosine of a 32-bit phase, one turn per 2^32.
// ----------------------------------------------------------------------------
module cordic_sine_cosine_top
    import cordic_sc_pkg::*;
#(
    parameter int ROTATION_STEPS = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] phase
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [31:0] sine, [63:32] cosine
);

    logic  valid_pipe [0:ROTATION_STEPS];
    logic  ready_pipe [0:ROTATION_STEPS+1];
    word_t x_pipe     [0:ROTATION_STEPS];
    word_t y_pipe     [0:ROTATION_STEPS];
    word_t z_pipe     [0:ROTATION_STEPS];

    logic  quad_valid_reg;
    word_t quad_x_reg, quad_z_reg;
    word_t quad_x_next, quad_z_next;

    // quadrant correction
    always_comb
    begin
        priority if (s_axis_tdata < QUARTER_TURN)
        begin
            quad_x_next = word_t'(0) - START_GAIN;
            quad_z_next = s_axis_tdata + QUARTER_TURN;
        end
        else if (s_axis_tdata < THREE_QUARTERS)
        begin
            quad_x_next = START_GAIN;
            quad_z_next = s_axis_tdata - QUARTER_TURN;
        end
        else
        begin
            quad_x_next = word_t'(0) - START_GAIN;
            quad_z_next = s_axis_tdata - THREE_QUARTERS;
        end
    end

    assign ready_pipe[0] = !quad_valid_reg || ready_pipe[1];
    assign s_axis_tready = ready_pipe[0];

    // sink ready seen by the last rotation stage
    assign ready_pipe[ROTATION_STEPS+1] = m_axis_tready;

    // quadrant stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quad_valid_reg <= 1'b0;
        else if (ready_pipe[0])
            quad_valid_reg <= s_axis_tvalid;
    end

    // quadrant stage payload
    always_ff @(posedge clk)
    begin
        if (ready_pipe[0] && s_axis_tvalid)
        begin
            quad_x_reg <= quad_x_next;
            quad_z_reg <= quad_z_next;
        end
    end

    assign valid_pipe[0] = quad_valid_reg;
    assign x_pipe[0]     = quad_x_reg;
    assign y_pipe[0]     = '0;
    assign z_pipe[0]     = quad_z_reg;

    // rotation stages
    for (genvar i = 0; i < ROTATION_STEPS; i++)
    begin : g_step
        cordic_sc_step #(
            .STEP (i)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_pipe[i]),
            .ready_up  (ready_pipe[i+1]),
            .x_in      (x_pipe[i]),
            .y_in      (y_pipe[i]),
            .z_in      (z_pipe[i]),
            .valid_out (valid_pipe[i+1]),
            .ready_dn  (ready_pipe[i+2]),
            .x_out     (x_pipe[i+1]),
            .y_out     (y_pipe[i+1]),
            .z_out     (z_pipe[i+1])
        );
    end

    // result
    assign m_axis_tvalid = valid_pipe[ROTATION_STEPS];
    assign m_axis_tdata  = {x_pipe[ROTATION_STEPS], y_pipe[ROTATION_STEPS]};

    // a ready sink lets every stage move, so the input is always ready
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    // an empty last stage can never stall the input
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // a full quadrant stage moving on shows up in the first rotation stage
    a_quad_advance: assert property (@(posedge clk) disable iff (!rst_n)
        quad_valid_reg && ready_pipe[1] |=> valid_pipe[1])
        else $error("transaction lost after quadrant stage");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined cordic sine and cosine block: phases
// go in on the slave stream, each result is checked against a bit-true
// rotation predictor, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import cordic_sc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROTATION_STEPS = 31;
    localparam int RANDOM_PHASES  = 1150;
    localparam int IDLE_PERCENT   = 17;
    localparam int DRAIN_CYCLES   = ROTATION_STEPS + 8;

    // one result transaction, laid out as on m_axis_tdata
    typedef struct packed {
        word_t cosine;
        word_t sine;
    } trig_pair_t;

    // directed phases: both ends of the range, quadrant borders and octants
    localparam int EDGE_COUNT = 22;
    localparam word_t EDGE_PHASES [0:EDGE_COUNT-1] = '{
        32'h00000000, 32'h00000001, 32'hffffffff, 32'hfffffffe,
        32'h3ffffffe, 32'h3fffffff, 32'h40000000, 32'h40000001,
        32'h7fffffff, 32'h80000000, 32'h80000001, 32'hbffffffc,
        32'hbffffffd, 32'hbffffffe, 32'hc0000000, 32'h20000000,
        32'h60000000, 32'ha0000000, 32'he0000000, 32'h55555555,
        32'haaaaaaaa, 32'h7ffffffe
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    trig_pair_t  expected_trig [$];
    int          mismatch_count = 0;
    logic        steady_run = 1'b0;

    cordic_sine_cosine_top #(
        .ROTATION_STEPS (ROTATION_STEPS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock, 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // quadrant fold then rotation steps, all sums wrap at 32 bits
    function automatic trig_pair_t rotate_phase(input word_t phase);
        word_t       x;
        word_t       y;
        word_t       z;
        word_t       x_sh;
        word_t       y_sh;
        int unsigned k;
        trig_pair_t  res;
        x = START_GAIN;
        y = '0;
        z = phase;
        if (z < QUARTER_TURN)
        begin
            x = -x;
            z = z + QUARTER_TURN;
        end
        else if (z < THREE_QUARTERS)
        begin
            z = z - QUARTER_TURN;
        end
        else
        begin
            x = -x;
            z = z - THREE_QUARTERS;
        end
        for (int i = 0; i < ROTATION_STEPS; i++)
        begin
            k    = i % 32;
            x_sh = $signed(x) >>> k;
            y_sh = $signed(y) >>> k;
            if (z >= QUARTER_TURN)
            begin
                x = x - y_sh;
                y = y + x_sh;
                z = z - STEP_ANGLES[k];
            end
            else
            begin
                x = x + y_sh;
                y = y - x_sh;
                z = z + STEP_ANGLES[k];
            end
        end
        res.sine   = y;
        res.cosine = x;
        return res;
    endfunction

    // random phase: half uniform, some near quadrant borders, some sparse bits
    function automatic word_t pick_phase();
        word_t border;
        word_t pattern;
        case ($urandom_range(3))
            2:
            begin
                case ($urandom_range(3))
                    0:       border = QUARTER_TURN;
                    1:       border = THREE_QUARTERS;
                    2:       border = 32'h80000000;
                    default: border = 32'h00000000;
                endcase
                return border + $urandom_range(16) - 8;
            end
            3:
            begin
                pattern = 32'h1 << $urandom_range(31);
                return $urandom_range(1) ? ~pattern : pattern;
            end
            default: return $urandom;
        endcase
    endfunction

    // slave side transaction, starts and ends on a falling edge
    task automatic send_phase(input word_t phase);
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= phase;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // master side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // predict on accepted phases, check accepted results in order
    always @(posedge clk)
    begin
        trig_pair_t want;
        trig_pair_t got;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_trig.push_back(rotate_phase(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_trig.size() == 0)
            begin
                $error("result with nothing expected: sine %h cosine %h",
                       got.sine, got.cosine);
                mismatch_count++;
            end
            else
            begin
                want = expected_trig.pop_front();
                if (got.sine !== want.sine)
                begin
                    $error("sine mismatch: expected %h, got %h", want.sine, got.sine);
                    mismatch_count++;
                end
                if (got.cosine !== want.cosine)
                begin
                    $error("cosine mismatch: expected %h, got %h",
                           want.cosine, got.cosine);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("** cordic_sine_cosine_top: FAILED **");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int i = 0; i < EDGE_COUNT; i++)
            send_phase(EDGE_PHASES[i]);

        // random phases, with one gap-free stretch and one full drain
        for (int n = 0; n < RANDOM_PHASES; n++)
        begin
            steady_run <= (n >= 400 && n < 650);
            if (n == 800)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
                while (expected_trig.size() != 0)
                    @(negedge clk);
            end
            send_phase(pick_phase());
        end
        s_axis_tvalid <= 1'b0;
        steady_run    <= 1'b0;

        while (expected_trig.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("** cordic_sine_cosine_top: PASSED **");
        else
            $display("** cordic_sine_cosine_top: FAILED **");
        $finish;
    end

endmodule

[files.f]
hdl/cordic_sc_pkg.sv
hdl/cordic_sc_step.sv
hdl/cordic_sine_cosine_top.sv
tb/tb_top.sv
